[hdl/ncas_pkg.sv]
// Package with the shared types, character codes and mode codes of the comment scanner.
`default_nettype none
package ncas_pkg;

  localparam int DEPTH_BITS = 16;
  localparam int CHAR_BITS  = 21;
  localparam int MODE_BITS  = 3;

  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [CHAR_BITS-1:0]  char_t;
  typedef logic [MODE_BITS-1:0]  mode_t;

  localparam depth_t DEPTH_MAX = {DEPTH_BITS{1'b1}};

  localparam char_t CH_LPAREN = 21'h00028;
  localparam char_t CH_RPAREN = 21'h00029;
  localparam char_t CH_SEMI   = 21'h0003B;
  localparam char_t CH_AT     = 21'h00040;
  localparam char_t CH_QUOTE  = 21'h00022;
  localparam char_t CH_BSLASH = 21'h0005C;
  localparam char_t CH_SPACE  = 21'h00020;
  localparam char_t CH_TAB    = 21'h00009;
  localparam char_t CH_LF     = 21'h0000A;
  localparam char_t CH_CR     = 21'h0000D;
  localparam char_t CH_BOM    = 21'h0FEFF;

  localparam mode_t M_IDLE = 3'd0;
  localparam mode_t M_OPEN = 3'd1;
  localparam mode_t M_CMT  = 3'd2;
  localparam mode_t M_ANN  = 3'd3;
  localparam mode_t M_ACMT = 3'd4;
  localparam mode_t M_STR  = 3'd5;
  localparam mode_t M_ESC  = 3'd6;
  localparam mode_t M_LINE = 3'd7;

  localparam logic [1:0] ST_INSIDE   = 2'd0;
  localparam logic [1:0] ST_SKIPPED  = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  localparam logic [1:0] KIND_COMMENT       = 2'd0;
  localparam logic [1:0] KIND_ANNOT_COMMENT = 2'd1;
  localparam logic [1:0] KIND_ANNOTATION    = 2'd2;

  // Allow flags: bit 0 plain comment, bit 1 annotation comment, bit 2 annotation.
  typedef struct packed {
    mode_t      mode;
    logic       pend_open;
    logic       pend_semi;
    depth_t     paren_depth;
    depth_t     cmt_depth;
    logic [2:0] allow;
  } scan_state_t;

  typedef struct packed {
    char_t      char_code;
    logic       end_of_input;
    logic [2:0] allow;
  } scan_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] kind;
    logic       consumed;
    logic       overflow;
  } scan_result_t;

endpackage
`default_nettype wire

[hdl/nested_comment_annotation_scanner.sv]
// Top level of the comment scanner: input register, scan state and result register.
// A request goes through the input register, then the result register that drives out_*.
// Throughput: one code point per cycle unless out_* stalls; the state update is a single
// pass of ncas_step. A stalled result holds; one more request waits in the input register.
// Reset (rst_n low, synchronous) empties both registers and returns the scanner to idle
// with both depths, the pending marks and the latched allow flags cleared.
`default_nettype none
module nested_comment_annotation_scanner (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  // char_code [20:0], allow_plain_comment [21], allow_annot_comment [22],
  // allow_annotation [23]
  input  wire [23:0] in_tdata,
  input  wire        in_tlast,
  output logic       out_tvalid,
  input  wire        out_tready,
  // scan_status [1:0], char_consumed [2], depth_overflow [3], zero [7:4]
  output logic [7:0] out_tdata,
  // token_kind [1:0]
  output logic [1:0] out_tuser
);

  logic                  s1_valid_r;
  ncas_pkg::scan_item_t  s1_item_r;
  ncas_pkg::scan_state_t state_r;
  ncas_pkg::scan_state_t state_nxt;
  ncas_pkg::scan_result_t res_nxt;
  ncas_pkg::scan_result_t res_r;
  logic                  out_valid_r;
  logic                  adv;
  logic                  fire;

  assign adv       = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  ncas_step u_step (
    .cur  (state_r),
    .item (s1_item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.char_code    <= in_tdata[20:0];
      s1_item_r.end_of_input <= in_tlast;
      s1_item_r.allow        <= in_tdata[23:21];
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.overflow, res_r.consumed, res_r.status};
  assign out_tuser  = res_r.kind;

`ifndef NO_ASSERTIONS
  a_ovf_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.overflow) |-> (res_r.status == ncas_pkg::ST_REJECTED))
    else $error("depth overflow reported without a rejection");

  a_reject_not_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == ncas_pkg::ST_REJECTED) |-> !res_r.consumed)
    else $error("rejected character marked as consumed");

  a_kind_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status != ncas_pkg::ST_COMPLETE)
      |-> (res_r.kind == ncas_pkg::KIND_COMMENT))
    else $error("token kind set without a completed token");

  a_end_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (res_nxt.status == ncas_pkg::ST_REJECTED ||
              res_nxt.status == ncas_pkg::ST_COMPLETE))
      |=> (state_r.mode == ncas_pkg::M_IDLE && state_r.paren_depth == '0 &&
           state_r.cmt_depth == '0))
    else $error("scanner not cleared after token end");
`endif

endmodule
`default_nettype wire

[hdl/ncas_step.sv]
// Next-state and result logic of the comment scanner for one code point.
`default_nettype none
module ncas_step (
  input  wire ncas_pkg::scan_state_t  cur,
  input  wire ncas_pkg::scan_item_t   item,
  output ncas_pkg::scan_state_t       nxt,
  output ncas_pkg::scan_result_t      res
);

  always_comb begin
    ncas_pkg::char_t  c;
    ncas_pkg::depth_t pd;
    logic             reject;
    logic             done;
    c      = item.char_code;
    pd     = cur.paren_depth;
    reject = 1'b0;
    done   = 1'b0;
    nxt    = cur;
    res.status   = ncas_pkg::ST_INSIDE;
    res.kind     = ncas_pkg::KIND_COMMENT;
    res.consumed = 1'b1;
    res.overflow = 1'b0;

    case (cur.mode)
      ncas_pkg::M_IDLE: begin
        nxt.allow = item.allow;
        if (item.allow == 3'b000 || item.end_of_input) begin
          reject = 1'b1;
        end else if (c inside {ncas_pkg::CH_SPACE, ncas_pkg::CH_TAB, ncas_pkg::CH_LF,
                               ncas_pkg::CH_CR, ncas_pkg::CH_BOM}) begin
          res.status = ncas_pkg::ST_SKIPPED;
        end else if (c == ncas_pkg::CH_LPAREN) begin
          nxt.mode = ncas_pkg::M_OPEN;
        end else begin
          reject = 1'b1;
        end
      end
      ncas_pkg::M_OPEN: begin
        if (item.end_of_input) begin
          reject = 1'b1;
        end else if (c == ncas_pkg::CH_AT && cur.allow[2]) begin
          nxt.mode        = ncas_pkg::M_ANN;
          nxt.paren_depth = ncas_pkg::DEPTH_BITS'(1);
        end else if (c == ncas_pkg::CH_SEMI && (cur.allow[1] || cur.allow[0])) begin
          nxt.mode      = ncas_pkg::M_CMT;
          nxt.cmt_depth = ncas_pkg::DEPTH_BITS'(1);
        end else begin
          reject = 1'b1;
        end
      end
      ncas_pkg::M_CMT, ncas_pkg::M_ACMT: begin
        if (item.end_of_input) begin
          reject = 1'b1;
        end else if (cur.pend_open && c == ncas_pkg::CH_SEMI) begin
          nxt.pend_open = 1'b0;
          nxt.pend_semi = 1'b0;
          if (cur.cmt_depth == ncas_pkg::DEPTH_MAX) begin
            reject       = 1'b1;
            res.overflow = 1'b1;
          end else begin
            nxt.cmt_depth = cur.cmt_depth + ncas_pkg::DEPTH_BITS'(1);
          end
        end else if (cur.pend_semi && c == ncas_pkg::CH_RPAREN) begin
          nxt.pend_open = 1'b0;
          nxt.pend_semi = 1'b0;
          nxt.cmt_depth = cur.cmt_depth - ncas_pkg::DEPTH_BITS'(1);
          if (cur.cmt_depth == ncas_pkg::DEPTH_BITS'(1)) begin
            if (cur.mode == ncas_pkg::M_CMT) begin
              res.status = ncas_pkg::ST_COMPLETE;
              res.kind   = cur.allow[1] ? ncas_pkg::KIND_ANNOT_COMMENT
                                        : ncas_pkg::KIND_COMMENT;
              done       = 1'b1;
            end else begin
              nxt.mode = ncas_pkg::M_ANN;
            end
          end
        end else begin
          nxt.pend_open = (c == ncas_pkg::CH_LPAREN);
          nxt.pend_semi = (c == ncas_pkg::CH_SEMI);
        end
      end
      ncas_pkg::M_ANN: begin
        if (item.end_of_input) begin
          reject = 1'b1;
        end else if (cur.pend_open && c == ncas_pkg::CH_SEMI) begin
          nxt.pend_open = 1'b0;
          nxt.cmt_depth = ncas_pkg::DEPTH_BITS'(1);
          nxt.mode      = ncas_pkg::M_ACMT;
        end else if (cur.pend_open && cur.paren_depth == ncas_pkg::DEPTH_MAX) begin
          reject       = 1'b1;
          res.overflow = 1'b1;
        end else if (!cur.pend_open && cur.pend_semi && c == ncas_pkg::CH_SEMI) begin
          nxt.pend_semi = 1'b0;
          nxt.mode      = ncas_pkg::M_LINE;
        end else begin
          // The opening paren still pending is now known to open a nested group.
          if (cur.pend_open) begin
            pd = cur.paren_depth + ncas_pkg::DEPTH_BITS'(1);
          end
          nxt.pend_open = 1'b0;
          nxt.pend_semi = 1'b0;
          if (c == ncas_pkg::CH_QUOTE) begin
            nxt.mode = ncas_pkg::M_STR;
          end else if (c == ncas_pkg::CH_LPAREN) begin
            nxt.pend_open = 1'b1;
          end else if (c == ncas_pkg::CH_SEMI) begin
            nxt.pend_semi = 1'b1;
          end else if (c == ncas_pkg::CH_RPAREN) begin
            pd = pd - ncas_pkg::DEPTH_BITS'(1);
            if (pd == '0) begin
              res.status = ncas_pkg::ST_COMPLETE;
              res.kind   = ncas_pkg::KIND_ANNOTATION;
              done       = 1'b1;
            end
          end
          nxt.paren_depth = pd;
        end
      end
      ncas_pkg::M_LINE: begin
        if (item.end_of_input) begin
          reject = 1'b1;
        end else if (c == ncas_pkg::CH_LF) begin
          nxt.mode = ncas_pkg::M_ANN;
        end
      end
      ncas_pkg::M_STR: begin
        if (item.end_of_input) begin
          reject = 1'b1;
        end else if (c == ncas_pkg::CH_QUOTE) begin
          nxt.mode = ncas_pkg::M_ANN;
        end else if (c == ncas_pkg::CH_BSLASH) begin
          nxt.mode = ncas_pkg::M_ESC;
        end
      end
      ncas_pkg::M_ESC: begin
        if (item.end_of_input) begin
          reject = 1'b1;
        end else begin
          nxt.mode = ncas_pkg::M_STR;
        end
      end
      default: begin
        reject = 1'b1;
      end
    endcase

    if (reject) begin
      res.status   = ncas_pkg::ST_REJECTED;
      res.kind     = ncas_pkg::KIND_COMMENT;
      res.consumed = 1'b0;
    end
    if (reject || done) begin
      nxt.mode        = ncas_pkg::M_IDLE;
      nxt.pend_open   = 1'b0;
      nxt.pend_semi   = 1'b0;
      nxt.paren_depth = '0;
      nxt.cmt_depth   = '0;
    end
  end

endmodule
`default_nettype wire
